// File: rtl/bitmask_queue_distributor_defines.svh
// ----------------------------------------------------------------------------
// Bitmask queue distributor assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BITMASK_QUEUE_DISTRIBUTOR_DEFINES_SVH
`define BITMASK_QUEUE_DISTRIBUTOR_DEFINES_SVH

`ifndef SYNTHESIS
`define BMQD_ASSERT(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("bmqd assertion failed");
`define BMQD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bmqd assertion failed");
`else
`define BMQD_ASSERT(label, expr)
`define BMQD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: rtl/bmqd_pkg.sv
// ----------------------------------------------------------------------------
// Bitmask queue distributor package
// Field widths, parameter defaults and the front-to-back queue entry.
// ----------------------------------------------------------------------------
package bmqd_pkg;

	localparam int MASK_W         = 32;
	localparam int QID_W          = 5;
	localparam int IDX_W          = 16;
	localparam int NUM_QUEUES_DEF = 32;
	localparam int INDEX_BITS_DEF = 16;
	localparam int QUEUE_DEPTH    = 2;

	typedef struct packed {
		logic [MASK_W-1:0] mask;
		logic [IDX_W-1:0]  idx;
		logic              sat;
	} entry_t;

	typedef struct packed {
		logic [$clog2(QUEUE_DEPTH+1)-1:0] count;
	} queue_stat_t;

	typedef struct packed {
		logic busy;
	} back_stat_t;

endpackage

// File: rtl/bmqd_in_if.sv
// ----------------------------------------------------------------------------
// Input channel
// One transaction carries a membership mask and a batch restart flag.
// ----------------------------------------------------------------------------
interface bmqd_in_if
	import bmqd_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [MASK_W-1:0] bit_mask;
	logic              first_in_batch;

	modport source (output valid, output bit_mask, output first_in_batch, input ready);
	modport sink (input valid, input bit_mask, input first_in_batch, output ready);
endinterface

// File: rtl/bmqd_out_if.sv
// ----------------------------------------------------------------------------
// Dispatch channel
// One transaction carries a queue number and the item's batch index.
// ----------------------------------------------------------------------------
interface bmqd_out_if
	import bmqd_pkg::*;
;
	logic             valid;
	logic             ready;
	logic [QID_W-1:0] queue_id;
	logic [IDX_W-1:0] item_index;
	logic             last_of_item;
	logic             index_saturated;

	modport source (output valid, output queue_id, output item_index,
		output last_of_item, output index_saturated, input ready);
	modport sink (input valid, input queue_id, input item_index,
		input last_of_item, input index_saturated, output ready);
endinterface

// File: rtl/bmqd_front.sv
// ----------------------------------------------------------------------------
// Bitmask queue distributor front end
// Numbers each item, drops unusable mask bits and queues nonempty items.
// ----------------------------------------------------------------------------
module bmqd_front
	import bmqd_pkg::*;
#(
	parameter int NUM_QUEUES = NUM_QUEUES_DEF,
	parameter int INDEX_BITS = INDEX_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	bmqd_in_if.sink    item_in,
	output logic       push_valid,
	output entry_t     push_data,
	input  logic       push_ready
);

	localparam int EXT_W = (INDEX_BITS > IDX_W) ? INDEX_BITS : IDX_W;
	localparam logic [INDEX_BITS-1:0] CNT_MAX = {INDEX_BITS{1'b1}};
	localparam logic [MASK_W-1:0] USE_MASK = (NUM_QUEUES >= MASK_W) ? {MASK_W{1'b1}} :
		MASK_W'((64'd1 << NUM_QUEUES) - 64'd1);

	logic [INDEX_BITS-1:0] cnt_q;
	logic [INDEX_BITS-1:0] base;
	logic [EXT_W-1:0]      base_ext;
	logic [MASK_W-1:0]     masked;
	logic                  sat;
	logic                  accept;

	always_comb begin
		base     = item_in.first_in_batch ? '0 : cnt_q;
		sat      = (base == CNT_MAX);
		base_ext = EXT_W'(base);
		masked   = item_in.bit_mask & USE_MASK;
	end

	assign item_in.ready  = push_ready;
	assign accept         = item_in.valid && item_in.ready;
	assign push_valid     = item_in.valid && (masked != '0);
	assign push_data.mask = masked;
	assign push_data.idx  = base_ext[IDX_W-1:0];
	assign push_data.sat  = sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= sat ? base : base + 1'b1;
		end
	end

endmodule

// File: rtl/bmqd_queue.sv
// ----------------------------------------------------------------------------
// Bitmask queue distributor decoupling queue
// Short FIFO of numbered items between the front and back ends.
// ----------------------------------------------------------------------------
module bmqd_queue
	import bmqd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push_valid,
	input  entry_t      push_data,
	output logic        push_ready,
	output logic        head_valid,
	output entry_t      head_data,
	input  logic        pop,
	output queue_stat_t stat
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	entry_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (cnt_q != CNT_FULL);
	assign head_valid = (cnt_q != '0);
	assign head_data  = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && head_valid;
	assign stat.count = cnt_q;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!do_push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/bmqd_back.sv
// ----------------------------------------------------------------------------
// Bitmask queue distributor back end
// Peels off the lowest set mask bit into the dispatch register each cycle that it can load.
// ----------------------------------------------------------------------------
module bmqd_back
	import bmqd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  entry_t     head_data,
	output logic       pop,
	bmqd_out_if.source disp_out,
	output back_stat_t stat
);

	entry_t            cur_q;
	logic              busy_q;
	logic              ovalid_q;
	logic [QID_W-1:0]  qid_q;
	logic [IDX_W-1:0]  idx_q;
	logic              last_q;
	logic              sat_q;

	entry_t            cur;
	logic [MASK_W-1:0] iso;
	logic [MASK_W-1:0] rem;
	logic [QID_W-1:0]  qid;
	logic              can_load;
	logic              fire;

	always_comb begin
		cur = busy_q ? cur_q : head_data;
		iso = cur.mask & (~cur.mask + 1'b1);
		rem = cur.mask & ~iso;
		qid = '0;
		for (int i = 0; i < MASK_W; i++) begin
			if (iso[i]) begin
				qid = qid | QID_W'(i);
			end
		end
	end

	assign can_load = !ovalid_q || disp_out.ready;
	assign fire     = (busy_q || head_valid) && can_load;
	assign pop      = fire && !busy_q;
	assign stat.busy = busy_q;

	assign disp_out.valid           = ovalid_q;
	assign disp_out.queue_id        = qid_q;
	assign disp_out.item_index      = idx_q;
	assign disp_out.last_of_item    = last_q;
	assign disp_out.index_saturated = sat_q;

	always_ff @(posedge clk) begin
		if (fire) begin
			qid_q      <= qid;
			idx_q      <= cur.idx;
			sat_q      <= cur.sat;
			last_q     <= (rem == '0);
			cur_q.mask <= rem;
			cur_q.idx  <= cur.idx;
			cur_q.sat  <= cur.sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (fire) begin
				ovalid_q <= 1'b1;
				busy_q   <= (rem != '0);
			end else if (disp_out.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/bitmask_queue_distributor.sv
// Path: an accepted item is written into the queue and then loaded from the queue head into
// the dispatch register, which drives its first dispatch.
// Throughput: one dispatch per cycle from the back end while the receiver is ready; an item
// gives one dispatch per set usable mask bit, and an item with no usable bit is not queued.
// A 2-entry queue lets the front take items while the back end works through a mask.
// Reset: arst_n clears the item counter, queue and dispatch register; no clearing pass.
// ----------------------------------------------------------------------------
// Bitmask queue distributor
// Expands each item's membership mask into per-queue dispatch transactions.
// ----------------------------------------------------------------------------
`include "bitmask_queue_distributor_defines.svh"

module bitmask_queue_distributor
	import bmqd_pkg::*;
#(
	parameter int NUM_QUEUES = NUM_QUEUES_DEF,
	parameter int INDEX_BITS = INDEX_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	bmqd_in_if.sink    item_in,
	bmqd_out_if.source disp_out
);

	localparam int EXT_W = (INDEX_BITS > IDX_W) ? INDEX_BITS : IDX_W;
	localparam logic [EXT_W-1:0] MAX_EXT = EXT_W'({INDEX_BITS{1'b1}});
	localparam logic [IDX_W-1:0] MAX_IDX = MAX_EXT[IDX_W-1:0];
	localparam logic [$clog2(QUEUE_DEPTH+1)-1:0] Q_FULL = ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH);

	logic        push_valid;
	logic        push_ready;
	entry_t      push_data;
	logic        head_valid;
	entry_t      head_data;
	logic        pop;
	queue_stat_t q_stat;
	back_stat_t  b_stat;

	bmqd_front #(
		.NUM_QUEUES (NUM_QUEUES),
		.INDEX_BITS (INDEX_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (item_in),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready)
	);

	bmqd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready),
		.head_valid (head_valid),
		.head_data  (head_data),
		.pop        (pop),
		.stat       (q_stat)
	);

	bmqd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_data  (head_data),
		.pop        (pop),
		.disp_out   (disp_out),
		.stat       (b_stat)
	);

	`BMQD_ASSERT(a_queue_bound, q_stat.count <= Q_FULL)
	`BMQD_ASSERT_NEXT(a_more_bits, disp_out.valid && disp_out.ready && !disp_out.last_of_item, disp_out.valid)
	`BMQD_ASSERT(a_busy_mid, !(disp_out.valid && !disp_out.last_of_item) || b_stat.busy)
	`BMQD_ASSERT(a_sat_index, !(disp_out.valid && disp_out.index_saturated) || disp_out.item_index == MAX_IDX)

endmodule

// File: sim/bitmask_queue_distributor_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bitmask queue distributor testbench
// Feeds membership masks with batch restarts and checks every dispatch
// against a model of the set-bit expansion.
// ----------------------------------------------------------------------------
import bmqd_pkg::*;

typedef struct packed {
	logic [QID_W-1:0] qid;
	logic [IDX_W-1:0] idx;
	logic             last;
	logic             sat;
} dispatch_t;

class dispatch_scoreboard;
	logic [IDX_W-1:0] next_index;
	dispatch_t        expected_q[$];
	int               errors;
	int               checked;
	int               items;

	function new();
		next_index = '0;
		errors     = 0;
		checked    = 0;
		items      = 0;
	endfunction

	// Expand one accepted transaction into its dispatches, lowest bit first.
	function void note_item(logic [MASK_W-1:0] mask, logic first);
		logic [MASK_W-1:0] left;
		logic [IDX_W-1:0]  idx;
		logic              sat;
		dispatch_t         d;
		items++;
		if (first)
			next_index = '0;
		idx  = next_index;
		sat  = (idx == {IDX_W{1'b1}});
		left = mask;
		for (int q = 0; q < MASK_W; q++) begin
			if (q >= NUM_QUEUES_DEF)
				left[q] = 1'b0;
		end
		for (int q = 0; q < MASK_W; q++) begin
			if (left[q]) begin
				left[q] = 1'b0;
				d.qid   = q[QID_W-1:0];
				d.idx   = idx;
				d.last  = (left == '0);
				d.sat   = sat;
				expected_q.push_back(d);
			end
		end
		if (!sat)
			next_index = idx + 1'b1;
	endfunction

	function void check_dispatch(dispatch_t got);
		dispatch_t e;
		if (expected_q.size() == 0) begin
			$display("%0t: unexpected dispatch, expected none, actual %p", $time, got);
			errors++;
			return;
		end
		e = expected_q.pop_front();
		checked++;
		if (got.qid !== e.qid) begin
			$display("%0t: queue_id mismatch, expected %0d, actual %0d", $time, e.qid, got.qid);
			errors++;
		end
		if (got.idx !== e.idx) begin
			$display("%0t: item_index mismatch, expected %0d, actual %0d",
				$time, e.idx, got.idx);
			errors++;
		end
		if (got.last !== e.last) begin
			$display("%0t: last_of_item mismatch, expected %0b, actual %0b",
				$time, e.last, got.last);
			errors++;
		end
		if (got.sat !== e.sat) begin
			$display("%0t: index_saturated mismatch, expected %0b, actual %0b",
				$time, e.sat, got.sat);
			errors++;
		end
	endfunction

	function int pending();
		return expected_q.size();
	endfunction
endclass

module bitmask_queue_distributor_tb;

	logic clk;
	logic arst_n;

	bmqd_in_if  item_ch ();
	bmqd_out_if disp_ch ();

	bitmask_queue_distributor dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.item_in  (item_ch),
		.disp_out (disp_ch)
	);

	dispatch_scoreboard sb = new();

	bit src_idle_on  = 1'b1;
	bit sink_idle_on = 1'b1;
	bit hold_request = 1'b0;
	int hold_left    = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("Some tests failed");
		$finish;
	end

	task automatic send_item(input logic [MASK_W-1:0] mask, input logic first,
		input bit may_idle);
		@(negedge clk);
		while (may_idle && src_idle_on && $urandom_range(0, 99) < 32) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid          <= 1'b1;
		item_ch.bit_mask       <= mask;
		item_ch.first_in_batch <= first;
		do
			@(posedge clk);
		while (!item_ch.ready);
		sb.note_item(mask, first);
	endtask

	task automatic wait_drain();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Dispatch receiver: random stalls plus one long hold-off on request.
	initial begin
		disp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left == 0 && hold_request) begin
				hold_request = 1'b0;
				hold_left    = 400;
			end
			if (hold_left > 0) begin
				disp_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				disp_ch.ready <= !(sink_idle_on && $urandom_range(0, 99) < 32);
			end
		end
	end

	always @(posedge clk) begin
		dispatch_t got;
		if (arst_n && disp_ch.valid && disp_ch.ready) begin
			got.qid  = disp_ch.queue_id;
			got.idx  = disp_ch.item_index;
			got.last = disp_ch.last_of_item;
			got.sat  = disp_ch.index_saturated;
			sb.check_dispatch(got);
		end
	end

	initial begin
		logic [MASK_W-1:0] mask;
		int                kind;

		arst_n                 = 1'b0;
		item_ch.valid          = 1'b0;
		item_ch.bit_mask       = '0;
		item_ch.first_in_batch = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty mask, single ends, full and alternating masks, restart
		send_item(32'h0000_0000, 1'b1, 1'b1);
		send_item(32'h0000_0001, 1'b0, 1'b1);
		send_item(32'h8000_0000, 1'b0, 1'b1);
		send_item(32'hFFFF_FFFF, 1'b0, 1'b1);
		send_item(32'hAAAA_AAAA, 1'b0, 1'b1);
		send_item(32'h5555_5555, 1'b0, 1'b1);
		send_item(32'h0000_0000, 1'b0, 1'b1);
		send_item(32'h0001_8000, 1'b0, 1'b1);
		send_item(32'h0000_0010, 1'b1, 1'b1);
		send_item(32'h8000_0001, 1'b0, 1'b1);
		send_item(32'h0F0F_F0F0, 1'b0, 1'b1);
		send_item(32'h0000_0000, 1'b1, 1'b1);
		send_item(32'h4000_0002, 1'b0, 1'b1);
		wait_drain();

		// more edge masks around a restart
		send_item(32'h8000_0101, 1'b0, 1'b1);
		send_item(32'h0000_0000, 1'b0, 1'b1);
		send_item(32'hFFFF_FFFF, 1'b0, 1'b1);
		send_item(32'h0000_0040, 1'b1, 1'b1);
		send_item(32'h0000_0080, 1'b0, 1'b1);
		wait_drain();

		for (int n = 0; n < 200; n++) begin
			if (n == 60)
				hold_request = 1'b1;
			if (n == 110) begin
				src_idle_on  = 1'b0;
				sink_idle_on = 1'b0;
			end
			if (n == 150) begin
				src_idle_on  = 1'b1;
				sink_idle_on = 1'b1;
			end
			kind = $urandom_range(0, 19);
			if (kind == 0)
				mask = '0;
			else if (kind < 4)
				mask = $urandom();
			else if (kind == 4)
				mask = '1;
			else begin
				mask = '0;
				repeat ($urandom_range(1, 4)) mask[$urandom_range(0, MASK_W-1)] = 1'b1;
			end
			send_item(mask, ($urandom_range(0, 19) == 0), 1'b1);
		end
		wait_drain();
		repeat (10) @(posedge clk);

		$display("Run covered %0d items and %0d checked dispatches, including edge masks,",
			sb.items, sb.checked);
		$display("batch restarts, random stalls and a long receiver hold-off.");
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/bmqd_pkg.sv
rtl/bmqd_in_if.sv
rtl/bmqd_out_if.sv
rtl/bmqd_front.sv
rtl/bmqd_queue.sv
rtl/bmqd_back.sv
rtl/bitmask_queue_distributor.sv
sim/bitmask_queue_distributor_tb.sv
